// ===== rtl/smpq_pkg.sv =====
package smpq_pkg;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_PEEK   = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_EMPTY   = 2'd3;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_SPACE = 2'd1;
   localparam logic [1:0] ERR_EMPTY = 2'd2;

   localparam int PRIO_W   = 15;
   localparam int HANDLE_W = 32;
   localparam int SIZE_W   = 5;

   typedef struct packed {
      logic [1:0]          op;
      logic [31:0]         item_handle;
      logic signed [15:0]  priority_req;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [31:0]         item_out;
      logic [4:0]          size;
      logic [1:0]          error_code;
   } rsp_type;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   typedef struct packed {
      logic load;
      logic execute;
   } ctrl_cmd_type;

   typedef struct packed {
      logic rsp_free;
   } ctrl_sts_type;

endpackage

// ===== rtl/smpq_ctrl.sv =====
module smpq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  smpq_pkg::ctrl_sts_type sts,
   output smpq_pkg::ctrl_cmd_type cmd
);

   smpq_pkg::state_type state_ff;
   smpq_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= smpq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd.load    = 1'b0;
      cmd.execute = 1'b0;
      req_stall   = 1'b1;
      case (state_ff)
         smpq_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = smpq_pkg::S_EXEC;
            end
         end
         smpq_pkg::S_EXEC: begin
            if (sts.rsp_free) begin
               cmd.execute = 1'b1;
               state_in    = smpq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = smpq_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/smpq_datapath.sv =====
module smpq_datapath #(
   parameter int CAPACITY = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  smpq_pkg::req_type      req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output smpq_pkg::rsp_type      rsp_data,
   input  smpq_pkg::ctrl_cmd_type cmd,
   output smpq_pkg::ctrl_sts_type sts
);

   localparam int CntW = $clog2(CAPACITY + 1);

   smpq_pkg::req_type req_ff;
   smpq_pkg::rsp_type rsp_ff;
   smpq_pkg::rsp_type rsp_in;
   logic              rsp_valid_ff;

   logic [smpq_pkg::PRIO_W-1:0]   prio_ff   [CAPACITY];
   logic [smpq_pkg::PRIO_W-1:0]   prio_in   [CAPACITY];
   logic [smpq_pkg::HANDLE_W-1:0] handle_ff [CAPACITY];
   logic [smpq_pkg::HANDLE_W-1:0] handle_in [CAPACITY];

   logic [CntW-1:0]   count_ff;
   logic [CntW-1:0]   count_in;
   logic [1:0]        error_ff;
   logic [1:0]        error_in;
   logic [CntW+4:0]   count_ext;

   logic [CAPACITY-1:0]          gt;
   logic [smpq_pkg::PRIO_W-1:0]  new_prio;
   logic                         arg_ok;
   logic                         full;
   logic                         empty;
   logic                         do_insert;
   logic                         do_remove;

   assign new_prio = req_ff.priority_req[smpq_pkg::PRIO_W-1:0];
   assign arg_ok   = (req_ff.item_handle != '0) && !req_ff.priority_req[15];
   assign full     = (count_ff == CntW'(CAPACITY));
   assign empty    = (count_ff == '0);

   // request and control decode
   always_comb begin
      count_in  = count_ff;
      error_in  = error_ff;
      do_insert = 1'b0;
      do_remove = 1'b0;
      rsp_in.status   = smpq_pkg::ST_INVALID;
      rsp_in.item_out = '0;
      case (req_ff.op)
         smpq_pkg::OP_INSERT: begin
            if (!arg_ok) begin
               rsp_in.status = smpq_pkg::ST_INVALID;
            end else if (full) begin
               rsp_in.status = smpq_pkg::ST_FULL;
               error_in      = smpq_pkg::ERR_SPACE;
            end else begin
               rsp_in.status = smpq_pkg::ST_OK;
               error_in      = smpq_pkg::ERR_NONE;
               do_insert     = 1'b1;
               count_in      = count_ff + CntW'(1);
            end
         end
         smpq_pkg::OP_REMOVE, smpq_pkg::OP_PEEK: begin
            if (empty) begin
               rsp_in.status = smpq_pkg::ST_EMPTY;
               error_in      = smpq_pkg::ERR_EMPTY;
            end else begin
               rsp_in.status   = smpq_pkg::ST_OK;
               rsp_in.item_out = handle_ff[0];
               error_in        = smpq_pkg::ERR_NONE;
               if (req_ff.op == smpq_pkg::OP_REMOVE) begin
                  do_remove = 1'b1;
                  count_in  = count_ff - CntW'(1);
               end
            end
         end
         default: begin
            rsp_in.status = smpq_pkg::ST_INVALID;
         end
      endcase
      count_ext         = {5'b0, count_in};
      rsp_in.size       = count_ext[smpq_pkg::SIZE_W-1:0];
      rsp_in.error_code = error_in;
   end

   // row of sorted cells
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      assign gt[g] = (CntW'(g) < count_ff) && (prio_ff[g] > new_prio);

      always_comb begin
         prio_in[g]   = prio_ff[g];
         handle_in[g] = handle_ff[g];
         if (do_insert) begin
            if (g > 0 && gt[(g > 0) ? g - 1 : 0]) begin
               prio_in[g]   = prio_ff[(g > 0) ? g - 1 : 0];
               handle_in[g] = handle_ff[(g > 0) ? g - 1 : 0];
            end else if (gt[g] || count_ff == CntW'(g)) begin
               prio_in[g]   = new_prio;
               handle_in[g] = req_ff.item_handle;
            end
         end else if (do_remove && g < CAPACITY - 1) begin
            prio_in[g]   = prio_ff[(g < CAPACITY - 1) ? g + 1 : g];
            handle_in[g] = handle_ff[(g < CAPACITY - 1) ? g + 1 : g];
         end
      end

      always_ff @(posedge clock) begin
         if (cmd.execute) begin
            prio_ff[g]   <= prio_in[g];
            handle_ff[g] <= handle_in[g];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         error_ff     <= smpq_pkg::ERR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.execute) begin
            count_ff     <= count_in;
            error_ff     <= error_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
      end
   end

   assign sts.rsp_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

endmodule

// ===== rtl/stable_min_priority_queue.sv =====
// Stable min-priority queue of (handle, priority) entries, kept sorted in a
// row of register cells so that equal priorities leave first-in, first-out.
// Request channel req_valid/req_stall/req_data carries op (insert, remove
// minimum, peek minimum), item_handle and priority_req. Result channel
// rsp_valid/rsp_stall/rsp_data returns one beat per request with status,
// item_out, size and the sticky error_code.
// A request beat is registered while the controller is idle; in the execute state every
// cell compares its priority with the new one in parallel, the row shifts
// and the result register loads. By the load-then-execute sequence of the
// controller, a new request is taken only after the last one has executed.
// The result register parts the two sides: a new request is taken while a
// result beat waits, but that request is held in execution until the waiting
// beat leaves. A stall on the result channel thus holds req_stall high.
// Synchronous reset empties the queue, clears the error code and drops any
// pending result; stored cells keep stale data that is never read.
module stable_min_priority_queue #(
   parameter int CAPACITY = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  smpq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output smpq_pkg::rsp_type rsp_data
);

   smpq_pkg::ctrl_cmd_type cmd;
   smpq_pkg::ctrl_sts_type sts;

   smpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   smpq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

// ===== tb/stable_min_priority_queue_tb.sv =====
module stable_min_priority_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY = 16;
   localparam int ITEMS_PER_PHASE = 508;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam logic [1:0] OP_UNDEFINED = 2'd3;

   typedef struct {
      smpq_pkg::req_type rq;
      bit                fixed;
      smpq_pkg::rsp_type want;
   } stim_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   smpq_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   smpq_pkg::rsp_type rsp_data;

   // queue image kept beside the block
   logic [14:0] held_prio [CAPACITY];
   logic [31:0] held_handle [CAPACITY];
   int          held = 0;
   logic [1:0]  sticky = smpq_pkg::ERR_NONE;

   smpq_pkg::rsp_type due_answers [$];
   stim_row_type      directed_rows [$];
   smpq_pkg::rsp_type predicted;
   smpq_pkg::rsp_type row_want = '0;
   bit      row_fixed = 1'b0;
   bit      filling = 1'b1;
   int      fail_count = 0;
   int      idle_cycles = 0;
   int      send_idle_pct = 13;
   int      recv_idle_pct = 63;
   int      phase;

   stable_min_priority_queue #(.CAPACITY(CAPACITY)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic smpq_pkg::rsp_type queue_answer(input smpq_pkg::req_type rq);
      smpq_pkg::rsp_type ans;
      int      slot;
      int      k;
      ans = '0;
      case (rq.op)
         smpq_pkg::OP_INSERT: begin
            if (rq.item_handle == 32'd0 || rq.priority_req[15]) begin
               ans.status = smpq_pkg::ST_INVALID;
            end else if (held >= CAPACITY) begin
               sticky = smpq_pkg::ERR_SPACE;
               ans.status = smpq_pkg::ST_FULL;
            end else begin
               // ties go behind the entries already held
               slot = 0;
               while (slot < held && held_prio[slot] <= rq.priority_req[14:0]) slot++;
               for (k = held; k > slot; k--) begin
                  held_prio[k] = held_prio[k - 1];
                  held_handle[k] = held_handle[k - 1];
               end
               held_prio[slot] = rq.priority_req[14:0];
               held_handle[slot] = rq.item_handle;
               held++;
               sticky = smpq_pkg::ERR_NONE;
               ans.status = smpq_pkg::ST_OK;
            end
         end
         smpq_pkg::OP_REMOVE, smpq_pkg::OP_PEEK: begin
            if (held == 0) begin
               sticky = smpq_pkg::ERR_EMPTY;
               ans.status = smpq_pkg::ST_EMPTY;
            end else begin
               ans.item_out = held_handle[0];
               if (rq.op == smpq_pkg::OP_REMOVE) begin
                  for (k = 1; k < held; k++) begin
                     held_prio[k - 1] = held_prio[k];
                     held_handle[k - 1] = held_handle[k];
                  end
                  held--;
               end
               sticky = smpq_pkg::ERR_NONE;
               ans.status = smpq_pkg::ST_OK;
            end
         end
         default: ans.status = smpq_pkg::ST_INVALID;
      endcase
      ans.size = 5'(held);
      ans.error_code = sticky;
      return ans;
   endfunction

   function automatic smpq_pkg::req_type random_request();
      smpq_pkg::req_type rq;
      int      pick;
      if ($urandom_range(24) == 0) filling = !filling;
      pick = $urandom_range(99);
      if (pick < 3) rq.op = OP_UNDEFINED;
      else if (pick < (filling ? 70 : 25)) rq.op = smpq_pkg::OP_INSERT;
      else if (pick < (filling ? 88 : 85)) rq.op = smpq_pkg::OP_REMOVE;
      else rq.op = smpq_pkg::OP_PEEK;
      rq.item_handle = ($urandom_range(24) == 0) ? 32'd0 : $urandom;
      case ($urandom_range(9))
         0: rq.priority_req = 16'($urandom);
         1: rq.priority_req = $urandom_range(1) ? 16'sh7FFF : 16'sh0000;
         default: rq.priority_req = 16'($urandom_range(7));
      endcase
      return rq;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      fail_count++;
   endtask

   task automatic check_answer(input smpq_pkg::rsp_type got, input smpq_pkg::rsp_type want);
      if (got.status !== want.status)
         report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.item_out !== want.item_out)
         report_mismatch($sformatf("item_out got %h want %h", got.item_out, want.item_out));
      if (got.size !== want.size)
         report_mismatch($sformatf("size got %0d want %0d", got.size, want.size));
      if (got.error_code !== want.error_code)
         report_mismatch($sformatf("error_code got %0d want %0d",
                                   got.error_code, want.error_code));
   endtask

   task automatic add_row(input logic [1:0] op, input logic [31:0] handle,
                          input logic [15:0] prio, input bit fixed,
                          input logic [1:0] st, input logic [31:0] item,
                          input logic [4:0] sz, input logic [1:0] err);
      stim_row_type row;
      row.rq.op = op;
      row.rq.item_handle = handle;
      row.rq.priority_req = prio;
      row.fixed = fixed;
      row.want.status = st;
      row.want.item_out = item;
      row.want.size = sz;
      row.want.error_code = err;
      directed_rows.push_back(row);
   endtask

   // called at a falling edge, returns at the falling edge after the beat
   task automatic send_beat(input smpq_pkg::req_type rq);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (due_answers.size() == 0) report_mismatch("result beat with nothing outstanding");
            else check_answer(rsp_data, due_answers.pop_front());
         end
         if (req_valid && !req_stall) begin
            predicted = queue_answer(req_data);
            due_answers.push_back(row_fixed ? row_want : predicted);
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
   end

   initial begin
      while (idle_cycles < STALL_LIMIT) @(negedge clock);
      $display("** stable_min_priority_queue: FAILED **");
      $finish;
   end

   initial begin
      add_row(smpq_pkg::OP_PEEK, 32'h0000_0000, 16'h0000, 1'b1,
              smpq_pkg::ST_EMPTY, 32'd0, 5'd0, smpq_pkg::ERR_EMPTY);
      add_row(smpq_pkg::OP_REMOVE, 32'h0000_0000, 16'h0000, 1'b1,
              smpq_pkg::ST_EMPTY, 32'd0, 5'd0, smpq_pkg::ERR_EMPTY);
      add_row(smpq_pkg::OP_INSERT, 32'h0000_0000, 16'h0005, 1'b1,
              smpq_pkg::ST_INVALID, 32'd0, 5'd0, smpq_pkg::ERR_EMPTY);
      add_row(smpq_pkg::OP_INSERT, 32'h0000_0001, 16'hFFFF, 1'b1,
              smpq_pkg::ST_INVALID, 32'd0, 5'd0, smpq_pkg::ERR_EMPTY);
      add_row(smpq_pkg::OP_INSERT, 32'hFFFF_FFFF, 16'h7FFF, 1'b1,
              smpq_pkg::ST_OK, 32'd0, 5'd1, smpq_pkg::ERR_NONE);
      add_row(OP_UNDEFINED, 32'h5A5A_A5A5, 16'h0003, 1'b1,
              smpq_pkg::ST_INVALID, 32'd0, 5'd1, smpq_pkg::ERR_NONE);
      add_row(smpq_pkg::OP_INSERT, 32'h0000_0001, 16'h0000, 1'b1,
              smpq_pkg::ST_OK, 32'd0, 5'd2, smpq_pkg::ERR_NONE);
      add_row(smpq_pkg::OP_INSERT, 32'h0000_0002, 16'h0000, 1'b1,
              smpq_pkg::ST_OK, 32'd0, 5'd3, smpq_pkg::ERR_NONE);
      add_row(smpq_pkg::OP_PEEK, 32'h0000_0000, 16'h0000, 1'b1,
              smpq_pkg::ST_OK, 32'd1, 5'd3, smpq_pkg::ERR_NONE);
      add_row(smpq_pkg::OP_INSERT, 32'h0000_0005, 16'h8000, 1'b1,
              smpq_pkg::ST_INVALID, 32'd0, 5'd3, smpq_pkg::ERR_NONE);
      // fill up, with ties spread through the row
      add_row(smpq_pkg::OP_INSERT, 32'h8000_0010, 16'd3, 1'b0,
              smpq_pkg::ST_OK, 32'd0, 5'd0, smpq_pkg::ERR_NONE);
      add_row(smpq_pkg::OP_INSERT, 32'h0000_0011, 16'd1, 1'b0,
              smpq_pkg::ST_OK, 32'd0, 5'd0, smpq_pkg::ERR_NONE);
      add_row(smpq_pkg::OP_INSERT, 32'h7FFF_FFFE, 16'd3, 1'b0,
              smpq_pkg::ST_OK, 32'd0, 5'd0, smpq_pkg::ERR_NONE);
      add_row(smpq_pkg::OP_INSERT, 32'h0000_0013, 16'd0, 1'b0,
              smpq_pkg::ST_OK, 32'd0, 5'd0, smpq_pkg::ERR_NONE);
      add_row(smpq_pkg::OP_INSERT, 32'h0000_0014, 16'd7, 1'b0,
              smpq_pkg::ST_OK, 32'd0, 5'd0, smpq_pkg::ERR_NONE);
      add_row(smpq_pkg::OP_INSERT, 32'hC000_0015, 16'd2, 1'b0,
              smpq_pkg::ST_OK, 32'd0, 5'd0, smpq_pkg::ERR_NONE);
      add_row(smpq_pkg::OP_INSERT, 32'h0000_0016, 16'd3, 1'b0,
              smpq_pkg::ST_OK, 32'd0, 5'd0, smpq_pkg::ERR_NONE);
      add_row(smpq_pkg::OP_INSERT, 32'h0000_0017, 16'h7FFE, 1'b0,
              smpq_pkg::ST_OK, 32'd0, 5'd0, smpq_pkg::ERR_NONE);
      add_row(smpq_pkg::OP_INSERT, 32'h0000_0018, 16'd1, 1'b0,
              smpq_pkg::ST_OK, 32'd0, 5'd0, smpq_pkg::ERR_NONE);
      add_row(smpq_pkg::OP_INSERT, 32'h0000_0019, 16'd0, 1'b0,
              smpq_pkg::ST_OK, 32'd0, 5'd0, smpq_pkg::ERR_NONE);
      add_row(smpq_pkg::OP_INSERT, 32'h0000_001A, 16'd5, 1'b0,
              smpq_pkg::ST_OK, 32'd0, 5'd0, smpq_pkg::ERR_NONE);
      add_row(smpq_pkg::OP_INSERT, 32'h0000_001B, 16'd3, 1'b0,
              smpq_pkg::ST_OK, 32'd0, 5'd0, smpq_pkg::ERR_NONE);
      add_row(smpq_pkg::OP_INSERT, 32'h0000_001C, 16'd2, 1'b0,
              smpq_pkg::ST_OK, 32'd0, 5'd0, smpq_pkg::ERR_NONE);
      add_row(smpq_pkg::OP_INSERT, 32'hA5A5_5A5A, 16'd100, 1'b1,
              smpq_pkg::ST_FULL, 32'd0, 5'd16, smpq_pkg::ERR_SPACE);
      add_row(smpq_pkg::OP_REMOVE, 32'h0000_0000, 16'h0000, 1'b0,
              smpq_pkg::ST_OK, 32'd0, 5'd0, smpq_pkg::ERR_NONE);

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[n]) begin
         row_fixed = directed_rows[n].fixed;
         row_want = directed_rows[n].want;
         send_beat(directed_rows[n].rq);
      end
      row_fixed = 1'b0;

      for (phase = 1; phase <= 3; phase++) begin
         repeat (ITEMS_PER_PHASE) send_beat(random_request());
         req_valid <= 1'b0;
         // hold off until every answer is back
         while (due_answers.size() != 0) @(negedge clock);
         @(posedge clock);
         send_idle_pct = (phase == 1) ? 63 : 0;
         recv_idle_pct = (phase == 1) ? 13 : 0;
         @(negedge clock);
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("** stable_min_priority_queue: PASSED **");
      end else begin
         $display("** stable_min_priority_queue: FAILED **");
      end
      $finish;
   end

endmodule
